// File: sv/brcs_pkg.sv
// Package for the byte range to CHS splitter: request and result types,
// geometry constants and register index codes. No dependencies.
`timescale 1ns / 1ps
package brcs_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned SEC_SHIFT    = 9;
  localparam int unsigned CYL_BITS     = 16;
  localparam int unsigned HD_BITS      = 4;
  localparam int unsigned PC_BITS      = 12;
  localparam int unsigned CAP_BITS     = 28;

  // Pipeline layout: input, sum, capacity, range check, cylinder steps, head steps.
  localparam int unsigned CYL_FIRST = 4;
  localparam int unsigned HD_FIRST  = CYL_FIRST + CYL_BITS;
  localparam int unsigned NSTAGE    = HD_FIRST + HD_BITS;

  typedef enum logic [1:0] {
    REG_SPT  = 2'd0,
    REG_HEAD = 2'd1,
    REG_CYL  = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    STEP_HEAD  = 3'd0,
    STEP_RUN   = 3'd1,
    STEP_TAIL  = 3'd2,
    STEP_DONE  = 3'd3,
    STEP_RANGE = 3'd4
  } step_kind_t;

  typedef struct packed {
    logic        kind;
    logic [35:0] byte_offset;
    logic [31:0] bytes_left;
  } in_t;

  typedef struct packed {
    logic [2:0]  step_kind;
    logic [15:0] cylinder;
    logic [3:0]  head;
    logic [7:0]  sector;
    logic [7:0]  sector_count;
    logic [8:0]  fragment_start;
    logic [9:0]  fragment_bytes;
    logic        merge_needed;
    logic [35:0] next_offset;
    logic [31:0] next_bytes_left;
  } out_t;

  // Work record that travels down the pipeline.
  typedef struct packed {
    logic                kind;
    logic [35:0]         offs;
    logic [31:0]         len;
    logic                gok;
    logic [36:0]         sum;
    logic [PC_BITS-1:0]  pc;
    logic [CAP_BITS-1:0] capsec;
    logic                oor;
    logic [PC_BITS-1:0]  rem;
    logic [CYL_BITS-1:0] cyl;
    logic [7:0]          r2;
    logic [HD_BITS-1:0]  hd;
  } item_t;

endpackage

// File: sv/brcs_step_calc.sv
// Final command decode of the byte range to CHS splitter.
// Depends on brcs_pkg for the work record and result types.
`timescale 1ns / 1ps
module brcs_step_calc (
  input  brcs_pkg::item_t it,
  input  logic [7:0]      spt,
  output brcs_pkg::out_t  res
);
  import brcs_pkg::*;

  logic [8:0]  sec_off;
  logic [9:0]  room;
  logic [9:0]  used;
  logic [22:0] nsec;
  logic [7:0]  track_left;
  logic [7:0]  n;
  logic [16:0] n_bytes;

  always_comb begin
    sec_off    = it.offs[8:0];
    room       = 10'(SECTOR_BYTES) - {1'b0, sec_off};
    used       = (it.len < {22'd0, room}) ? it.len[9:0] : room;
    nsec       = it.len[31:SEC_SHIFT];
    track_left = spt - it.r2;
    n          = (nsec > {15'd0, track_left}) ? track_left : nsec[7:0];
    n_bytes    = {n, 9'd0};

    // Out-of-range values are the defaults.
    res.step_kind       = STEP_RANGE;
    res.cylinder        = '0;
    res.head            = '0;
    res.sector          = 8'd1;
    res.sector_count    = '0;
    res.fragment_start  = '0;
    res.fragment_bytes  = '0;
    res.merge_needed    = 1'b0;
    res.next_offset     = it.offs;
    res.next_bytes_left = it.len;

    if (!it.oor) begin
      if (it.len == 32'd0) begin
        res.step_kind = STEP_DONE;
      end else begin
        res.cylinder = it.cyl;
        res.head     = it.hd;
        res.sector   = it.r2 + 8'd1;
        if (sec_off != 9'd0) begin
          // Unaligned start: one partial sector, at most up to the boundary.
          res.step_kind       = STEP_HEAD;
          res.sector_count    = 8'd1;
          res.fragment_start  = sec_off;
          res.fragment_bytes  = used;
          res.merge_needed    = it.kind;
          res.next_offset     = it.offs + {26'd0, room};
          res.next_bytes_left = it.len - {22'd0, used};
        end else if (it.len > 32'(SECTOR_BYTES)) begin
          // Whole sectors, capped at the end of the track.
          res.step_kind       = STEP_RUN;
          res.sector_count    = n;
          res.next_offset     = it.offs + {19'd0, n_bytes};
          res.next_bytes_left = it.len - {15'd0, n_bytes};
        end else begin
          res.step_kind       = STEP_TAIL;
          res.sector_count    = 8'd1;
          res.fragment_bytes  = it.len[9:0];
          res.merge_needed    = it.kind;
          res.next_offset     = it.offs + {4'd0, it.len};
          res.next_bytes_left = '0;
        end
      end
    end
  end

endmodule

// File: sv/byte_range_to_chs_splitter.sv
// Top level of the byte range to CHS splitter: geometry registers, range check
// and pipelined cylinder and head dividers. Depends on brcs_pkg, brcs_step_calc.
`timescale 1ns / 1ps
// Usage: a request (kind, byte offset, bytes left) enters on the in_ channel
// and one command result leaves on the out_ channel for every request.
// A request is taken at a clock edge with in_valid high and in_stall low;
// a result is taken with out_valid high and out_stall low.
// Geometry is written through cfg_we / cfg_index / cfg_wdata while idle.
// A request passes the input stage, then the sum, capacity and range check
// stages; sixteen restoring-division steps then give the
// cylinder, four more give the head, and the command decode feeds the
// output register. One request is accepted every cycle; the whole
// pipeline advances together, so it holds only while a finished result
// sits unclaimed in the output register with out_stall high, and then
// in_stall is raised. Nothing is lost or repeated during a stall.
// Reset clears all valid bits and loads 63 sectors, 16 heads and
// 1024 cylinders.
module byte_range_to_chs_splitter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  brcs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output brcs_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_wdata
);
  import brcs_pkg::*;

  logic [7:0]  spt_r;
  logic [4:0]  heads_r;
  logic [15:0] cyls_r;
  logic        en;
  logic        v_r [NSTAGE];
  item_t       st_r [NSTAGE];
  item_t       st0_nxt;
  out_t        res;
  out_t        out_r;
  logic        out_valid_r;

  // Geometry registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= 8'd63;
      heads_r <= 5'd16;
      cyls_r  <= 16'd1024;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SPT:  spt_r   <= cfg_wdata[7:0];
        REG_HEAD: heads_r <= cfg_wdata[4:0];
        REG_CYL:  cyls_r  <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being read.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_comb begin
    st0_nxt             = '0;
    st0_nxt.kind        = in_data.kind;
    st0_nxt.offs        = in_data.byte_offset;
    st0_nxt.len         = in_data.bytes_left;
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0_nxt;
    end
  end

  // Remaining stages: sum, capacity and range check, then one quotient bit per stage.
  for (genvar k = 1; k < NSTAGE; k++) begin : g_stage
    item_t st_nxt;

    if (k == 1) begin : g_sum
      // End of range and sectors per cylinder.
      always_comb begin
        st_nxt     = st_r[k-1];
        st_nxt.sum = {1'b0, st_r[k-1].offs} + {5'd0, st_r[k-1].len};
        st_nxt.pc  = PC_BITS'(spt_r * heads_r);
        st_nxt.gok = (spt_r != 8'd0) && (heads_r != 5'd0) && (heads_r <= 5'd16)
                     && (cyls_r != 16'd0);
      end
    end else if (k == 2) begin : g_cap
      always_comb begin
        st_nxt        = st_r[k-1];
        st_nxt.capsec = CAP_BITS'(st_r[k-1].pc * cyls_r);
      end
    end else if (k == 3) begin : g_check
      // Range check and division setup with the top bits of the LBA.
      always_comb begin
        st_nxt     = st_r[k-1];
        st_nxt.oor = !st_r[k-1].gok ||
                     (st_r[k-1].sum >= {st_r[k-1].capsec, 9'd0});
        st_nxt.rem = {1'b0, st_r[k-1].offs[35:25]};
      end
    end else if (k < HD_FIRST) begin : g_cyl
      logic [12:0] tc;

      // Cylinder division step.
      always_comb begin
        st_nxt = st_r[k-1];
        tc     = {st_r[k-1].rem, st_r[k-1].offs[24 - (k - CYL_FIRST)]};
        st_nxt.cyl[CYL_BITS - 1 - (k - CYL_FIRST)] = (tc >= {1'b0, st_r[k-1].pc});
        st_nxt.rem = (tc >= {1'b0, st_r[k-1].pc}) ?
                     PC_BITS'(tc - {1'b0, st_r[k-1].pc}) : tc[11:0];
      end
    end else begin : g_hd
      logic [8:0] th;
      logic [7:0] r2_in;

      // Head division step on the remainder within the cylinder.
      always_comb begin
        st_nxt = st_r[k-1];
        r2_in  = (k == HD_FIRST) ? st_r[k-1].rem[11:4] : st_r[k-1].r2;
        th     = {r2_in, st_r[k-1].rem[HD_BITS - 1 - (k - HD_FIRST)]};
        st_nxt.hd[HD_BITS - 1 - (k - HD_FIRST)] = (th >= {1'b0, spt_r});
        st_nxt.r2 = (th >= {1'b0, spt_r}) ? 8'(th - {1'b0, spt_r}) : th[7:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  // Command decode into the output register.
  brcs_step_calc u_calc (
    .it  (st_r[NSTAGE-1]),
    .spt (spt_r),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NSTAGE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
